>>> hdl/ptpd_pkg.sv
// ----------------------------------------------------------------------------
// ptpd_pkg
// Shared types, constants and helper functions of the point transform unit.
// ----------------------------------------------------------------------------
package ptpd_pkg;

  // fixed point format and register file
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int NUM_REGS  = 8;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 4;
  localparam int PROD_W    = 2 * COORD_W;

  // column sums: three floored products plus a translation term
  localparam int SUM_W  = PROD_W - FRAC_BITS + 2;
  // magnitudes of sums and divisor, and the divider remainder
  localparam int REM_W  = SUM_W - 1;
  localparam int QUO_W  = COORD_W;
  localparam int OVF_SH = QUO_W - FRAC_BITS;
  localparam int DIV_STAGES = QUO_W;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // fixed point one and zero
  localparam logic [COORD_W-1:0] FIX_ONE  = COORD_W'(1) << FRAC_BITS;
  localparam logic [COORD_W-1:0] FIX_ZERO = '0;

  // register reset values, identity matrix
  localparam logic [CFG_W-1:0] REG_RESET [NUM_REGS] = '{
    {FIX_ZERO, FIX_ONE}, {FIX_ZERO, FIX_ZERO},
    {FIX_ONE, FIX_ZERO}, {FIX_ZERO, FIX_ZERO},
    {FIX_ZERO, FIX_ZERO}, {FIX_ZERO, FIX_ONE},
    {FIX_ZERO, FIX_ZERO}, {FIX_ONE, FIX_ZERO}
  };

  typedef logic [NUM_REGS-1:0][CFG_W-1:0] coef_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] result_x;
    logic signed [COORD_W-1:0] result_y;
    logic signed [COORD_W-1:0] result_z;
    logic                      w_was_zero;
    logic                      saturated;
  } result_t;

  // transformed point before the divide
  typedef struct packed {
    logic [2:0][SUM_W-1:0] num;
    logic [SUM_W-1:0]      w;
  } sums_t;

  // one component in flight through the divider
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] dd;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             ovf;
    logic             npos;
    logic             nneg;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [2:0]  lane;
    logic [REM_W-1:0] divisor;
    logic             w_zero;
  } div_stage_t;

  // matrix entry at row r, column c
  function automatic logic signed [COORD_W-1:0] mat_entry(coef_t coef, logic [1:0] r,
                                                          logic [1:0] c);
    logic [CFG_W-1:0] reg_val;
    reg_val = coef[{r, c[1]}];
    return c[0] ? reg_val[CFG_W-1:COORD_W] : reg_val[COORD_W-1:0];
  endfunction

  // product shifted right by the fraction bits, floor, sign extended
  function automatic logic [SUM_W-1:0] scale_prod(logic [PROD_W-1:0] p);
    return {{2{p[PROD_W-1]}}, p[PROD_W-1:FRAC_BITS]};
  endfunction

  // one restoring division step, one quotient bit
  function automatic div_lane_t div_step(div_lane_t l, logic [REM_W-1:0] d);
    div_lane_t        n;
    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;
    n     = l;
    trial = {l.rem, l.dd[QUO_W-1]};
    diff  = trial - {1'b0, d};
    n.dd  = {l.dd[QUO_W-2:0], 1'b0};
    if (trial >= {1'b0, d}) begin
      n.rem = diff[REM_W-1:0];
      n.quo = {l.quo[QUO_W-2:0], 1'b1};
    end else begin
      n.rem = trial[REM_W-1:0];
      n.quo = {l.quo[QUO_W-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

>>> hdl/ptpd_front.sv
// ----------------------------------------------------------------------------
// ptpd_front
// Accepts points and forms the four column sums of the matrix product.
// ----------------------------------------------------------------------------
module ptpd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptpd_pkg::coef_t               coef_i,
  input  logic                          in_valid_i,
  input  ptpd_pkg::point_t              point_i,
  input  logic                          adv_i,
  output logic                          out_valid_o,
  output ptpd_pkg::sums_t               sums_o
);

  logic                               va_q, vb_q, vc_q;
  ptpd_pkg::point_t                   pt_q;
  logic [ptpd_pkg::PROD_W-1:0]        prod_q [3][4];
  ptpd_pkg::sums_t                    sums_q;
  logic signed [ptpd_pkg::COORD_W-1:0] coord [3];

  assign coord[0] = pt_q.point_x;
  assign coord[1] = pt_q.point_y;
  assign coord[2] = pt_q.point_z;

  // stage valid bits, frozen while the queue is full
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // input register, products, column sums
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pt_q <= point_i;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod_q[r][c] <= coord[r] * ptpd_pkg::mat_entry(coef_i, 2'(r), 2'(c));
        end
      end
      for (int c = 0; c < 3; c++) begin
        sums_q.num[c] <= ptpd_pkg::scale_prod(prod_q[0][c])
                       + ptpd_pkg::scale_prod(prod_q[1][c])
                       + ptpd_pkg::scale_prod(prod_q[2][c])
                       + ptpd_pkg::SUM_W'(ptpd_pkg::mat_entry(coef_i, 2'd3, 2'(c)));
      end
      sums_q.w <= ptpd_pkg::scale_prod(prod_q[0][3])
                + ptpd_pkg::scale_prod(prod_q[1][3])
                + ptpd_pkg::scale_prod(prod_q[2][3])
                + ptpd_pkg::SUM_W'(ptpd_pkg::mat_entry(coef_i, 2'd3, 2'd3));
    end
  end

  assign out_valid_o = vc_q;
  assign sums_o      = sums_q;

endmodule

>>> hdl/ptpd_queue.sv
// ----------------------------------------------------------------------------
// ptpd_queue
// Short queue between the front and the divider back end.
// ----------------------------------------------------------------------------
module ptpd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ptpd_pkg::sums_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output ptpd_pkg::sums_t data_o
);

  ptpd_pkg::sums_t             mem_q [ptpd_pkg::QDEPTH];
  logic [ptpd_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [ptpd_pkg::QPTR_W:0]   cnt_q;
  logic                        do_push, do_pop;

  assign full_o  = (cnt_q == (ptpd_pkg::QPTR_W+1)'(ptpd_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

>>> hdl/ptpd_back.sv
// ----------------------------------------------------------------------------
// ptpd_back
// Perspective divide: sign handling, pipelined restoring divider, saturation.
// ----------------------------------------------------------------------------
module ptpd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  ptpd_pkg::sums_t   in_data_i,
  output logic              in_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output ptpd_pkg::result_t result_o
);

  localparam int NS = ptpd_pkg::DIV_STAGES;
  localparam int OW = ptpd_pkg::REM_W + ptpd_pkg::OVF_SH;

  ptpd_pkg::div_stage_t       stg_q [NS+1];
  logic [NS:0]                vld_q;
  ptpd_pkg::div_stage_t       prep;
  logic                       out_v_q;
  ptpd_pkg::result_t          out_q;
  ptpd_pkg::result_t          res_d;
  logic                       adv;
  logic [ptpd_pkg::SUM_W-1:0] wabs;
  logic [ptpd_pkg::SUM_W-1:0] nabs [3];
  logic [ptpd_pkg::COORD_W-1:0] comp [3];
  logic [2:0]                 sat_c;

  assign adv      = !out_v_q || pop_i;
  assign in_pop_o = adv && in_valid_i;

  // operand preparation: magnitudes, signs, early overflow check
  always_comb begin
    wabs = in_data_i.w[ptpd_pkg::SUM_W-1] ? -in_data_i.w : in_data_i.w;
    prep.divisor = wabs[ptpd_pkg::REM_W-1:0];
    prep.w_zero  = (in_data_i.w == '0);
    for (int c = 0; c < 3; c++) begin
      nabs[c] = in_data_i.num[c][ptpd_pkg::SUM_W-1] ? -in_data_i.num[c] : in_data_i.num[c];
      prep.lane[c].rem  = {{ptpd_pkg::OVF_SH{1'b0}},
                           nabs[c][ptpd_pkg::REM_W-1:ptpd_pkg::OVF_SH]};
      prep.lane[c].dd   = {nabs[c][ptpd_pkg::OVF_SH-1:0], {ptpd_pkg::FRAC_BITS{1'b0}}};
      prep.lane[c].quo  = '0;
      prep.lane[c].neg  = in_data_i.num[c][ptpd_pkg::SUM_W-1] ^ in_data_i.w[ptpd_pkg::SUM_W-1];
      prep.lane[c].ovf  = OW'({{ptpd_pkg::OVF_SH{1'b0}}, nabs[c][ptpd_pkg::REM_W-1:0]})
                          >= OW'({wabs[ptpd_pkg::REM_W-1:0], {ptpd_pkg::OVF_SH{1'b0}}});
      prep.lane[c].nneg = in_data_i.num[c][ptpd_pkg::SUM_W-1];
      prep.lane[c].npos = !in_data_i.num[c][ptpd_pkg::SUM_W-1] && (in_data_i.num[c] != '0);
    end
  end

  // divider stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-1:0], in_valid_i};
    end
  end

  // divider stages, one quotient bit each
  always_ff @(posedge clk_i) begin
    if (adv) begin
      stg_q[0] <= prep;
      for (int s = 1; s <= NS; s++) begin
        stg_q[s].divisor <= stg_q[s-1].divisor;
        stg_q[s].w_zero  <= stg_q[s-1].w_zero;
        for (int c = 0; c < 3; c++) begin
          stg_q[s].lane[c] <= ptpd_pkg::div_step(stg_q[s-1].lane[c], stg_q[s-1].divisor);
        end
      end
    end
  end

  // saturation and sign restore
  always_comb begin
    logic [ptpd_pkg::QUO_W:0]   limit;
    logic [ptpd_pkg::QUO_W-1:0] mag;
    ptpd_pkg::div_lane_t        l;
    for (int c = 0; c < 3; c++) begin
      l        = stg_q[NS].lane[c];
      limit    = {1'b0, l.neg, {(ptpd_pkg::QUO_W-1){!l.neg}}};
      sat_c[c] = l.ovf || ({1'b0, l.quo} > limit);
      mag      = sat_c[c] ? limit[ptpd_pkg::QUO_W-1:0] : l.quo;
      if (stg_q[NS].w_zero) begin
        comp[c] = l.npos ? {1'b0, {(ptpd_pkg::COORD_W-1){1'b1}}} :
                  l.nneg ? {1'b1, {(ptpd_pkg::COORD_W-1){1'b0}}} : '0;
      end else begin
        comp[c] = l.neg ? -mag : mag;
      end
    end
    res_d.result_x   = comp[0];
    res_d.result_y   = comp[1];
    res_d.result_z   = comp[2];
    res_d.w_was_zero = stg_q[NS].w_zero;
    res_d.saturated  = !stg_q[NS].w_zero && (sat_c != '0);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= res_d;
  end

  assign empty_o  = !out_v_q;
  assign result_o = out_q;

endmodule

>>> hdl/point_transform_perspective_divide_unit.sv
// Path: input, product and sum registers, queue, operand register, restoring
// divider (32 stages, one quotient bit each, three lanes), output register.
// Pipelined: one point per cycle unless a full queue or unpopped result stalls.
// Reset: rst_ni clears all valid state and loads the identity matrix.
// ----------------------------------------------------------------------------
// point_transform_perspective_divide_unit
// 4x4 homogeneous point transform in Q16.16 with perspective divide.
// ----------------------------------------------------------------------------
module point_transform_perspective_divide_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ptpd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ptpd_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                             push,
  output logic                             full,
  input  ptpd_pkg::point_t                 point_i,
  output logic                             empty,
  input  logic                             pop,
  output ptpd_pkg::result_t                result_o
);

  ptpd_pkg::coef_t coef_q;
  logic            q_full, q_empty, q_pop;
  logic            f_valid;
  ptpd_pkg::sums_t f_sums, q_data;

  // matrix registers, out-of-range writes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ptpd_pkg::NUM_REGS; i++) coef_q[i] <= ptpd_pkg::REG_RESET[i];
    end else if (cfg_we_i && (cfg_idx_i < ptpd_pkg::CFG_IDX_W'(ptpd_pkg::NUM_REGS))) begin
      coef_q[cfg_idx_i[2:0]] <= cfg_data_i;
    end
  end

  assign full = q_full;

  ptpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_q),
    .in_valid_i  (push && !q_full),
    .point_i     (point_i),
    .adv_i       (!q_full),
    .out_valid_o (f_valid),
    .sums_o      (f_sums)
  );

  ptpd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (f_sums),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_data)
  );

  ptpd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (!q_empty),
    .in_data_i  (q_data),
    .in_pop_o   (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .result_o   (result_o)
  );

endmodule

>>> sim/tb_point_transform_perspective_divide_unit.sv
// ----------------------------------------------------------------------------
// tb_point_transform_perspective_divide_unit
// Pushes points through the 4x4 transform with perspective divide under
// several matrices, predicts every result in fixed point and checks each
// popped result field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_point_transform_perspective_divide_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 37;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [ptpd_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [ptpd_pkg::CFG_W-1:0]     cfg_data_i = '0;
  logic                           push = 1'b0;
  logic                           full;
  ptpd_pkg::point_t               point_i = '0;
  logic                           empty;
  logic                           pop = 1'b0;
  ptpd_pkg::result_t              result_o;

  point_transform_perspective_divide_unit u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push, .full, .point_i, .empty, .pop, .result_o
  );

  always #1 clk_i = ~clk_i;

  logic [ptpd_pkg::CFG_W-1:0] matrix_regs [ptpd_pkg::NUM_REGS];
  ptpd_pkg::point_t           pending_points [$];
  ptpd_pkg::result_t          expected_results [$];
  int                         mismatch_cnt = 0;
  bit                         idle_enable = 1'b1;
  bit                         pop_hold = 1'b0;
  int                         push_gap = 0;
  int                         pop_gap = 0;

  // matrix entry from the shadow registers
  function automatic longint entry_at(int r, int c);
    logic [ptpd_pkg::CFG_W-1:0] rv;
    rv = matrix_regs[r * 2 + c / 2];
    return (c % 2) ? longint'($signed(rv[63:32])) : longint'($signed(rv[31:0]));
  endfunction

  function automatic longint column_total(int c, longint x, longint y, longint z);
    return ((x * entry_at(0, c)) >>> ptpd_pkg::FRAC_BITS)
         + ((y * entry_at(1, c)) >>> ptpd_pkg::FRAC_BITS)
         + ((z * entry_at(2, c)) >>> ptpd_pkg::FRAC_BITS) + entry_at(3, c);
  endfunction

  // quotient (num << FRAC_BITS) / w toward zero, saturated
  function automatic logic [31:0] divide_sat(longint num, longint w, ref bit sat);
    bit          neg;
    logic [63:0] n, d, ip, rem, q, lim;
    neg = (num < 0) != (w < 0);
    n   = num < 0 ? -num : num;
    d   = w < 0 ? -w : w;
    ip  = n / d;
    rem = n % d;
    q   = ip;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (ip > (64'd1 << (32 - ptpd_pkg::FRAC_BITS))) begin
      q = lim + 1;
    end else begin
      for (int i = 0; i < ptpd_pkg::FRAC_BITS; i++) begin
        rem = rem << 1;
        q   = q << 1;
        if (rem >= d) begin
          rem = rem - d;
          q   = q | 1;
        end
      end
    end
    if (q > lim) begin
      sat = 1'b1;
      q   = lim;
    end
    return neg ? 32'(-q) : q[31:0];
  endfunction

  function automatic ptpd_pkg::result_t transform_point(ptpd_pkg::point_t p);
    ptpd_pkg::result_t r;
    longint            num [3];
    longint            w;
    bit                sat;
    logic [31:0]       o [3];
    sat = 1'b0;
    for (int c = 0; c < 3; c++) num[c] = column_total(c, p.point_x, p.point_y, p.point_z);
    w = column_total(3, p.point_x, p.point_y, p.point_z);
    for (int c = 0; c < 3; c++) begin
      if (w == 0) begin
        o[c] = num[c] > 0 ? 32'h7FFF_FFFF : (num[c] < 0 ? 32'h8000_0000 : 32'h0);
      end else begin
        o[c] = divide_sat(num[c], w, sat);
      end
    end
    r.result_x   = o[0];
    r.result_y   = o[1];
    r.result_z   = o[2];
    r.w_was_zero = (w == 0);
    r.saturated  = sat;
    return r;
  endfunction

  // driver: offer pending points, predict on each transfer
  always @(posedge clk_i) begin
    if (push && !full) begin
      expected_results.push_back(transform_point(point_i));
      void'(pending_points.pop_front());
    end
    if (push_gap > 0) begin
      push_gap <= push_gap - 1;
      push     <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 19) == 0) begin
      push_gap <= $urandom_range(1, 16) - 1;
      push     <= 1'b0;
    end else begin
      // next point is the head once the accepted one is removed
      push <= pending_points.size() > 0;
      if (pending_points.size() > 0) point_i <= pending_points[0];
    end
  end

  // monitor: compare each popped result with the oldest expectation
  always @(posedge clk_i) begin
    if (pop && !empty) begin
      if (expected_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %h", result_o);
      end else begin
        ptpd_pkg::result_t e;
        e = expected_results.pop_front();
        if (e.result_x !== result_o.result_x || e.result_y !== result_o.result_y ||
            e.result_z !== result_o.result_z || e.w_was_zero !== result_o.w_was_zero ||
            e.saturated !== result_o.saturated) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected %h actual %h", e, result_o);
        end
      end
    end
    if (pop_hold) begin
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap <= pop_gap - 1;
      pop     <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 19) == 0) begin
      pop_gap <= $urandom_range(1, 16) - 1;
      pop     <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic write_reg(int idx, logic [ptpd_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= ptpd_pkg::CFG_IDX_W'(idx);
    cfg_data_i <= val;
    if (idx < ptpd_pkg::NUM_REGS) matrix_regs[idx] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain_all();
    while (pending_points.size() > 0 || push || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(0, 65535 * 4)) - 131072);
      2:       return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      3:       return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
      4:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 2000)) - 1000) << 16;
    endcase
  endfunction

  function automatic logic [ptpd_pkg::CFG_W-1:0] rand_pair();
    logic [31:0] a, b;
    a = rand_coord();
    b = rand_coord();
    if ($urandom_range(0, 2) == 0) a = 32'($signed($urandom_range(0, 8)) - 4) << 16;
    return {b, a};
  endfunction

  task automatic add_random(int n);
    ptpd_pkg::point_t p;
    repeat (n) begin
      p.point_x = rand_coord();
      p.point_y = rand_coord();
      p.point_z = rand_coord();
      pending_points.push_back(p);
    end
  endtask

  initial begin
    ptpd_pkg::point_t p;
    for (int i = 0; i < ptpd_pkg::NUM_REGS; i++) matrix_regs[i] = ptpd_pkg::REG_RESET[i];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: identity, extremes of each field, zero point
    foreach (p.point_x[b]) begin
      p = '0;
      p.point_x = 32'h1 << b;
      p.point_y = ~(32'h1 << b);
      p.point_z = 32'(b) << 16;
      if (b % 4 == 0) pending_points.push_back(p);
    end
    pending_points.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0});
    pending_points.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF});
    pending_points.push_back('0);
    drain_all();

    // projection where w = z: zero w, saturation, out-of-range index
    write_reg(6, 64'h0);
    write_reg(7, 64'h0);
    write_reg(5, {32'h0001_0000, 32'h0001_0000});
    write_reg(ptpd_pkg::NUM_REGS + 3, 64'hDEAD_BEEF_DEAD_BEEF);
    pending_points.push_back('{32'h0001_0000, 32'hFFFF_0000, 32'h0});
    pending_points.push_back('{32'h0, 32'h0, 32'h0});
    pending_points.push_back('{32'h7FFF_0000, 32'h8000_0000, 32'h0000_0001});
    pending_points.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF});
    pending_points.push_back('{32'h0003_0000, 32'h0002_0000, 32'h0002_0000});
    add_random(100);

    // long receiver stall while the sender keeps pushing
    pop_hold = 1'b1;
    repeat (200) @(posedge clk_i);
    pop_hold = 1'b0;
    drain_all();

    // random phases, extreme matrices among them
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < ptpd_pkg::NUM_REGS; i++) begin
        case (ph)
          0:       write_reg(i, 64'hFFFF_FFFF_FFFF_FFFF);
          1:       write_reg(i, {32'h7FFF_FFFF, 32'h8000_0000});
          default: write_reg(i, rand_pair());
        endcase
      end
      add_random(130);
      drain_all();
    end

    // last part without idling
    idle_enable = 1'b0;
    for (int i = 0; i < ptpd_pkg::NUM_REGS; i++) write_reg(i, ptpd_pkg::REG_RESET[i]);
    write_reg(7, {32'h0002_0000, 32'h0});
    add_random(50);
    drain_all();

    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
